### rtl/odo_pkg.sv
// odometry package: register indexes, fixed-point constants, cordic arctangent table
// and the rounding and saturation helpers
// no dependencies
package odo_pkg;

  localparam int AddrWidth = 4;
  localparam int DivSteps  = 50;
  localparam int CordSteps = 16;

  // register indexes
  localparam logic [1:0] REG_RADIUS  = 2'd0;
  localparam logic [1:0] REG_SPACING = 2'd1;
  localparam logic [1:0] REG_TICK    = 2'd2;

  localparam logic [15:0] RADIUS_RST  = 16'd8;
  localparam logic [15:0] SPACING_RST = 16'd53;
  localparam logic [15:0] TICK_RST    = 16'd655;

  // round(2^32 / (2 pi)) and cordic start value 1/gain in Q30
  localparam logic [31:0] INV_TWO_PI   = 32'd683565276;
  localparam logic signed [31:0] CORD_X0 = 32'sd652032874;
  localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;

  // arctangent of 2^-i in units of 2^32 per turn
  function automatic logic [31:0] atan_step(input logic [3:0] i);
    logic [31:0] v;
    begin
      unique case (i)
        4'd0:  v = 32'h20000000;
        4'd1:  v = 32'h12E4051E;
        4'd2:  v = 32'h09FB385B;
        4'd3:  v = 32'h051111D4;
        4'd4:  v = 32'h028B0D43;
        4'd5:  v = 32'h0145D7E1;
        4'd6:  v = 32'h00A2F61E;
        4'd7:  v = 32'h00517C55;
        4'd8:  v = 32'h0028BE53;
        4'd9:  v = 32'h00145F2F;
        4'd10: v = 32'h000A2F98;
        4'd11: v = 32'h000517CC;
        4'd12: v = 32'h00028BE6;
        4'd13: v = 32'h000145F3;
        4'd14: v = 32'h0000A2FA;
        default: v = 32'h0000517D;
      endcase
      return v;
    end
  endfunction

  // product over 2^30, rounded half away from zero
  function automatic logic signed [38:0] rnd30(input logic signed [66:0] p);
    logic [66:0] mag;
    logic [67:0] t;
    logic [37:0] q;
    begin
      mag = p[66] ? 67'(-p) : 67'(p);
      t   = {1'b0, mag} + 68'(1 << 29);
      q   = t[67:30];
      return p[66] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    begin
      if (v > 40'sd2147483647)
        r = 32'sh7FFFFFFF;
      else if (v < -40'sd2147483648)
        r = 32'sh80000000;
      else
        r = v[31:0];
      return r;
    end
  endfunction

endpackage

### rtl/odo_div.sv
// odometry restoring divider, one quotient bit per cycle
// depends on odo_pkg
module odo_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [odo_pkg::DivSteps-1:0]  dividend,
  input  logic [15:0]                   divisor,
  output logic                          done,
  output logic [odo_pkg::DivSteps-1:0]  quotient
);
  import odo_pkg::*;

  localparam int CntW = $clog2(DivSteps);

  logic            busy;
  logic [CntW-1:0] cnt;
  logic [15:0]     rem;
  logic [16:0]     trial;
  logic            fits;

  // trial subtract of the divisor from the shifted remainder
  assign trial = {rem, quotient[DivSteps-1]};
  assign fits  = trial >= {1'b0, divisor};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(DivSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? 16'(trial - {1'b0, divisor}) : trial[15:0];
      quotient <= {quotient[DivSteps-2:0], fits};
    end
  end

endmodule

### rtl/odo_cordic.sv
// odometry cosine and sine of a binary angle, one cordic rotation per cycle
// depends on odo_pkg
module odo_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        heading,
  output logic               done,
  output logic signed [31:0] cos_q30,
  output logic signed [31:0] sin_q30
);
  import odo_pkg::*;

  logic               busy;
  logic [3:0]         idx;
  logic               flip;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [31:0] z;
  logic signed [31:0] xs;
  logic signed [31:0] ys;
  logic signed [31:0] xc;
  logic signed [31:0] yc;
  logic               flip_in;

  // left half plane is turned by half a turn
  assign flip_in = heading[15] ^ heading[14];
  assign xs      = x >>> idx;
  assign ys      = y >>> idx;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        idx <= idx + 1'b1;
        if (idx == 4'(CordSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // rotation datapath
  always_ff @(posedge clk) begin
    if (start) begin
      flip <= flip_in;
      x    <= CORD_X0;
      y    <= '0;
      z    <= $signed({heading[15] ^ flip_in, heading[14:0], 16'h0000});
    end else if (busy) begin
      if (!z[31]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - $signed(atan_step(idx));
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + $signed(atan_step(idx));
      end
    end
  end

  // clamp to the unit and undo the half turn
  always_comb begin
    xc = (x > Q30_ONE) ? Q30_ONE : ((x < -Q30_ONE) ? -Q30_ONE : x);
    yc = (y > Q30_ONE) ? Q30_ONE : ((y < -Q30_ONE) ? -Q30_ONE : y);
    cos_q30 = flip ? -xc : xc;
    sin_q30 = flip ? -yc : yc;
  end

endmodule

### rtl/differential_drive_odometry.sv
// differential-drive odometry top level: apb registers, sequencer, shared multiplier
// depends on odo_pkg, odo_div, odo_cordic
// a place word goes straight to the output state; a tick word runs the 50-step heading
// divider and the 16-step cordic, and skips the divider when spacing is 0
// a new word is taken only in idle, after the last one is emitted; out_stall holds the output
// reset: pose cleared, registers to 8, 53, 655, no word pending
module differential_drive_odometry (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           kind,
  input  logic signed [15:0]             left_speed,
  input  logic signed [15:0]             right_speed,
  input  logic signed [31:0]             x_in,
  input  logic signed [31:0]             y_in,
  input  logic [15:0]                    heading_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [31:0]             x_out,
  output logic signed [31:0]             y_out,
  output logic [15:0]                    heading_out,
  output logic [31:0]                    step_distance,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [odo_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import odo_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ML   = 4'd1;
  localparam logic [3:0] S_MR   = 4'd2;
  localparam logic [3:0] S_AD   = 4'd3;
  localparam logic [3:0] S_MD   = 4'd4;
  localparam logic [3:0] S_MS   = 4'd5;
  localparam logic [3:0] S_RD   = 4'd6;
  localparam logic [3:0] S_DW   = 4'd7;
  localparam logic [3:0] S_MRL  = 4'd8;
  localparam logic [3:0] S_MRH  = 4'd9;
  localparam logic [3:0] S_HD   = 4'd10;
  localparam logic [3:0] S_CW   = 4'd11;
  localparam logic [3:0] S_MC   = 4'd12;
  localparam logic [3:0] S_MSN  = 4'd13;
  localparam logic [3:0] S_UP   = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  logic [3:0] state;

  logic [15:0] radius;
  logic [15:0] wheel_spacing;
  logic [15:0] tick_time;

  logic signed [31:0] stored_x;
  logic signed [31:0] stored_y;
  logic [15:0]        stored_heading;

  logic signed [15:0] ls_q;
  logic signed [15:0] rs_q;
  logic signed [32:0] left;
  logic signed [33:0] diff;
  logic signed [33:0] sum;
  logic               nsign;
  logic signed [50:0] r;
  logic [55:0]        p1;
  logic signed [34:0] d;
  logic [31:0]        step;
  logic signed [31:0] c_q;
  logic signed [31:0] s_q;
  logic signed [38:0] dx;

  logic signed [34:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [66:0] mul_p;

  logic               accept;
  logic               cfg_wr;
  logic               emit;
  logic signed [32:0] rgt;
  logic signed [49:0] n;
  logic [49:0]        nmag;
  logic [50:0]        dsum;
  logic [33:0]        dm;
  logic [55:0]        acc;
  logic [15:0]        heading_next;
  logic signed [38:0] dy;

  logic               div_start;
  logic               div_done;
  logic [DivSteps-1:0] div_q;
  logic               cor_start;
  logic               cor_done;
  logic [15:0]        cor_heading;
  logic signed [31:0] cor_c;
  logic signed [31:0] cor_s;

  assign accept   = in_valid && !in_stall;
  assign in_stall = state != S_IDLE;
  assign emit     = (state == S_OUT) && (!out_valid || !out_stall);

  // apb register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius        <= RADIUS_RST;
      wheel_spacing <= SPACING_RST;
      tick_time     <= TICK_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_RADIUS:  radius        <= pwdata[15:0];
        REG_SPACING: wheel_spacing <= pwdata[15:0];
        REG_TICK:    tick_time     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RADIUS:  prdata = {16'h0000, radius};
      REG_SPACING: prdata = {16'h0000, wheel_spacing};
      REG_TICK:    prdata = {16'h0000, tick_time};
      default:     prdata = '0;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_ML:  begin mul_a = 35'(ls_q); mul_b = {16'h0000, tick_time}; end
      S_MR:  begin mul_a = 35'(rs_q); mul_b = {16'h0000, tick_time}; end
      S_MD:  begin mul_a = 35'(diff); mul_b = {16'h0000, radius}; end
      S_MS:  begin mul_a = 35'(sum);  mul_b = {16'h0000, radius}; end
      S_MRL: begin mul_a = {11'h000, r[23:0]}; mul_b = INV_TWO_PI; end
      S_MRH: begin mul_a = 35'($signed(r[50:24])); mul_b = INV_TWO_PI; end
      S_MC:  begin mul_a = d; mul_b = c_q; end
      S_MSN: begin mul_a = d; mul_b = s_q; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // product taps and rounding
  always_comb begin
    rgt  = mul_p[32:0];
    n    = mul_p[49:0];
    nmag = n[49] ? 50'(-n) : 50'(n);
    dsum = {1'b0, nmag} + 51'(65536);
    dm   = dsum[50:17];
    acc  = p1 + {mul_p[31:0], 24'h000000} + 56'h0000_8000_000000;
    heading_next = stored_heading + acc[55:40];
    dy   = rnd30(mul_p);
  end

  assign div_start   = (state == S_MS) && (wheel_spacing != 16'h0000);
  assign cor_start   = ((state == S_RD) && (wheel_spacing == 16'h0000)) || (state == S_HD);
  assign cor_heading = (state == S_HD) ? heading_next : stored_heading;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      stored_x       <= '0;
      stored_y       <= '0;
      stored_heading <= '0;
      step           <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (kind) begin
              stored_x       <= x_in;
              stored_y       <= y_in;
              stored_heading <= heading_in;
              step           <= '0;
              state          <= S_OUT;
            end else begin
              state <= S_ML;
            end
          end
        end
        S_ML:  state <= S_MR;
        S_MR:  state <= S_AD;
        S_AD:  state <= S_MD;
        S_MD:  state <= S_MS;
        S_MS:  state <= S_RD;
        S_RD: begin
          step  <= (dm[33:32] != 2'b00) ? 32'hFFFFFFFF : dm[31:0];
          state <= (wheel_spacing != 16'h0000) ? S_DW : S_CW;
        end
        S_DW:  if (div_done) state <= S_MRL;
        S_MRL: state <= S_MRH;
        S_MRH: state <= S_HD;
        S_HD: begin
          stored_heading <= heading_next;
          state          <= S_CW;
        end
        S_CW:  if (cor_done) state <= S_MC;
        S_MC:  state <= S_MSN;
        S_MSN: state <= S_UP;
        S_UP: begin
          stored_x <= sat32(40'(stored_x) + 40'(dx));
          stored_y <= sat32(40'(stored_y) + 40'(dy));
          state    <= S_OUT;
        end
        S_OUT: if (emit) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // working registers of a tick
  always_ff @(posedge clk) begin
    if (accept) begin
      ls_q <= left_speed;
      rs_q <= right_speed;
    end
    if (state == S_MR) left <= mul_p[32:0];
    if (state == S_AD) begin
      diff <= 34'(rgt) - 34'(left);
      sum  <= 34'(rgt) + 34'(left);
    end
    if (state == S_MS) nsign <= n[49];
    if (state == S_RD) d <= n[49] ? -35'(dm) : 35'(dm);
    if (state == S_DW && div_done)
      r <= nsign ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    if (state == S_MRH) p1 <= mul_p[55:0];
    if (state == S_CW && cor_done) begin
      c_q <= cor_c;
      s_q <= cor_s;
    end
    if (state == S_MSN) dx <= rnd30(mul_p);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      x_out         <= stored_x;
      y_out         <= stored_y;
      heading_out   <= stored_heading;
      step_distance <= step;
    end
  end

  odo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (nmag + 50'(wheel_spacing[15:1])),
    .divisor  (wheel_spacing),
    .done     (div_done),
    .quotient (div_q)
  );

  odo_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .heading (cor_heading),
    .done    (cor_done),
    .cos_q30 (cor_c),
    .sin_q30 (cor_s)
  );

  // checks
  a_tick_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && !kind) |=> state == S_ML) else $error("tick did not start sequence");
  a_place_pose: assert property (@(posedge clk) disable iff (rst)
    (accept && kind) |=> stored_heading == $past(heading_in)) else $error("place lost heading");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DW) else $error("divider finished outside wait");
  a_cor_done: assert property (@(posedge clk) disable iff (rst)
    cor_done |-> state == S_CW) else $error("cordic finished outside wait");

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// testbench for differential_drive_odometry: directed and random place and tick words
// checked against a fixed-point pose predictor; depends on odo_pkg and the rtl top level
module tb;
  import odo_pkg::*;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_PLACE = 1'b1;
  localparam int   IDLE_LIMIT = 5000;
  localparam longint Q30 = 64'sd1073741824;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        heading;
    logic [31:0]        step_len;
  } pose_t;

  logic clk, rst;
  logic in_valid, in_stall, kind;
  logic signed [15:0] left_speed, right_speed;
  logic signed [31:0] x_in, y_in;
  logic [15:0] heading_in;
  logic out_valid, out_stall;
  logic signed [31:0] x_out, y_out;
  logic [15:0] heading_out;
  logic [31:0] step_distance;
  logic psel, penable, pwrite, pready;
  logic [AddrWidth-1:0] paddr;
  logic [31:0] pwdata, prdata;

  differential_drive_odometry DUT (.*);

  // predictor state and register copies
  longint unsigned radius_q, spacing_q, tick_q;
  logic signed [31:0] pose_x, pose_y;
  logic [15:0] pose_heading;
  pose_t pose_queue[$];
  int fail_count, word_count, tick_count, place_count, result_count, idle_cycles;
  bit free_run;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint div_round(input longint num, input longint unsigned den);
    longint unsigned mag, q;
    begin
      mag = (num < 0) ? longint'(-num) : longint'(num);
      q = (mag + den / 2) / den;
      return (num < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic longint clamp_unit(input longint v);
    begin
      if (v > Q30) return Q30;
      if (v < -Q30) return -Q30;
      return v;
    end
  endfunction

  function automatic longint sat_pos(input longint v);
    begin
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    end
  endfunction

  // cordic rotation of the binary-angle heading, returns cos and sin in Q30
  task automatic rotate_unit(input logic [15:0] hd, output longint c, output longint s);
    logic [31:0] a;
    logic [31:0] t;
    logic flip;
    longint xr, yr, zr, xs, ys;
    begin
      a = {hd, 16'h0000};
      t = a + 32'h40000000;
      flip = t[31];
      if (flip) a = a + 32'h80000000;
      zr = longint'($signed(a));
      xr = 64'(CORD_X0);
      yr = 0;
      for (int i = 0; i < CordSteps; i++) begin
        xs = xr >>> i;
        ys = yr >>> i;
        if (zr >= 0) begin
          xr = xr - ys; yr = yr + xs; zr = zr - longint'(atan_step(4'(i)));
        end else begin
          xr = xr + ys; yr = yr - xs; zr = zr + longint'(atan_step(4'(i)));
        end
      end
      xr = clamp_unit(xr);
      yr = clamp_unit(yr);
      c = flip ? -xr : xr;
      s = flip ? -yr : yr;
    end
  endtask

  // advance the pose for one accepted word and queue the expected result
  task automatic advance_pose(input logic k, input logic signed [15:0] ls,
                              input logic signed [15:0] rs, input logic signed [31:0] xi,
                              input logic signed [31:0] yi, input logic [15:0] hi);
    longint lw, rw, diff, sum, r, d, c, s, dx, dy;
    longint unsigned bam, mag;
    pose_t p;
    begin
      p.step_len = '0;
      if (k == KIND_PLACE) begin
        pose_x = xi; pose_y = yi; pose_heading = hi;
      end else begin
        lw = longint'(ls) * longint'(tick_q);
        rw = longint'(rs) * longint'(tick_q);
        diff = rw - lw;
        sum = rw + lw;
        if (spacing_q != 0) begin
          r = div_round(diff * longint'(radius_q), spacing_q);
          bam = (longint'(r) * 64'd683565276 + (64'd1 << 39)) >> 40;
          pose_heading = pose_heading + bam[15:0];
        end
        d = div_round(sum * longint'(radius_q), 64'd131072);
        rotate_unit(pose_heading, c, s);
        dx = div_round(d * c, 64'd1073741824);
        dy = div_round(d * s, 64'd1073741824);
        pose_x = 32'(sat_pos(longint'(pose_x) + dx));
        pose_y = 32'(sat_pos(longint'(pose_y) + dy));
        mag = (d < 0) ? longint'(-d) : longint'(d);
        p.step_len = (mag > 64'hFFFFFFFF) ? 32'hFFFFFFFF : mag[31:0];
      end
      p.x = pose_x; p.y = pose_y; p.heading = pose_heading;
      pose_queue.insert(pose_queue.size(), p);
    end
  endtask

  function automatic int pick_gap();
    int r;
    begin
      if (free_run) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
    end
  endfunction

  // send one word and wait for it to be taken
  task automatic send_word(input logic k, input logic signed [15:0] ls,
                           input logic signed [15:0] rs, input logic signed [31:0] xi,
                           input logic signed [31:0] yi, input logic [15:0] hi);
    int gap;
    begin
      in_valid <= 1'b1;
      kind <= k; left_speed <= ls; right_speed <= rs;
      x_in <= xi; y_in <= yi; heading_in <= hi;
      do @(posedge clk); while (in_stall);
      advance_pose(k, ls, rs, xi, yi, hi);
      word_count++;
      if (k == KIND_PLACE) place_count++; else tick_count++;
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_tick(input logic signed [15:0] ls, input logic signed [15:0] rs);
    send_word(KIND_TICK, ls, rs, $urandom, $urandom, 16'($urandom));
  endtask

  task automatic send_place(input logic signed [31:0] xi, input logic signed [31:0] yi,
                            input logic [15:0] hi);
    send_word(KIND_PLACE, 16'($urandom), 16'($urandom), xi, yi, hi);
  endtask

  // lower valid, then wait until every expected result is back
  task automatic drain();
    begin
      in_valid <= 1'b0;
      while (pose_queue.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
    end
  endtask

  // apb write: setup phase, access phase, then the bus returns to idle
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    begin
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= AddrWidth'({idx, 2'b00}); pwdata <= {16'h0000, val};
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(posedge clk);
      case (idx)
        REG_RADIUS:  radius_q = 64'(val);
        REG_SPACING: spacing_q = 64'(val);
        default:     tick_q = 64'(val);
      endcase
    end
  endtask

  task automatic set_geometry(input logic [15:0] rad, input logic [15:0] spc,
                              input logic [15:0] tk);
    begin
      drain();
      write_reg(REG_RADIUS, rad);
      write_reg(REG_SPACING, spc);
      write_reg(REG_TICK, tk);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    pose_t e;
    if (!rst && out_valid && !out_stall) begin
      result_count++;
      if (pose_queue.size() == 0) begin
        $error("result with nothing expected");
        fail_count++;
      end else begin
        e = pose_queue.pop_front();
        if (x_out !== e.x) begin
          $error("x_out expected %0d actual %0d", e.x, x_out); fail_count++;
        end
        if (y_out !== e.y) begin
          $error("y_out expected %0d actual %0d", e.y, y_out); fail_count++;
        end
        if (heading_out !== e.heading) begin
          $error("heading_out expected %0d actual %0d", e.heading, heading_out);
          fail_count++;
        end
        if (step_distance !== e.step_len) begin
          $error("step_distance expected %0d actual %0d", e.step_len, step_distance);
          fail_count++;
        end
      end
    end
  end

  // receiver stall: mostly short, a few long, none while free-running
  int stall_left;
  always @(posedge clk) begin
    int r;
    if (rst || free_run) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_stall <= 1'b0;
      end else if (r < 95) begin
        out_stall <= 1'b1; stall_left <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1; stall_left <= $urandom_range(15, 40);
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic test_directed();
    begin
      send_place(32'sh7FFFFF00, 32'sh80000100, 16'h0000);
      send_tick(16'sh7FFF, 16'sh7FFF);
      send_tick(16'sh8000, 16'sh8000);
      send_place(32'sh80000000, 32'sh7FFFFFFF, 16'h8000);
      send_tick(16'sh7FFF, 16'sh7FFF);
      send_place(0, 0, 16'hFFFF);
      send_tick(16'sh0000, 16'sh0000);
      send_tick(16'sh8000, 16'sh7FFF);
      send_tick(16'sh7FFF, 16'sh8000);
      send_tick(16'sh0100, 16'sh0200);
      send_tick(-16'sh0100, 16'sh0080);
      send_place(32'sh12345678, -32'sh00ABCDEF, 16'h4000);
      send_tick(16'sh0400, 16'sh0400);
      send_place(0, 0, 16'hC000);
      send_tick(16'sh0400, 16'sh0400);
    end
  endtask

  task automatic test_extreme_geometry();
    begin
      // largest wheel, narrowest base, longest tick
      set_geometry(16'hFFFF, 16'h0001, 16'hFFFF);
      send_place(0, 0, 16'h0000);
      send_tick(16'sh7FFF, 16'sh7FFF);
      send_tick(16'sh8000, 16'sh7FFF);
      send_tick(16'sh8000, 16'sh8000);
      send_tick(16'sh0123, -16'sh0456);
      // smallest wheel and tick, widest base
      set_geometry(16'h0001, 16'hFFFF, 16'h0001);
      send_tick(16'sh7FFF, 16'sh8000);
      send_tick(16'sh0001, 16'sh0001);
      // zero spacing leaves the heading alone
      set_geometry(16'd100, 16'd0, 16'd3000);
      send_tick(16'sh0500, -16'sh0300);
      send_tick(16'sh7FFF, 16'sh8000);
    end
  endtask

  // random ticks with occasional places under one geometry
  task automatic random_phase(input int n);
    logic signed [15:0] ls, rs;
    int r;
    begin
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          send_place($urandom, $urandom, 16'($urandom));
        end else begin
          if (r < 50) begin
            ls = 16'($urandom); rs = 16'($urandom);
          end else begin
            ls = $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
            rs = ls + ($signed(16'($urandom_range(0, 255))) - 16'sd128);
          end
          send_tick(ls, rs);
        end
      end
    end
  endtask

  task automatic test_random();
    begin
      set_geometry(RADIUS_RST, SPACING_RST, TICK_RST);
      random_phase(400);
      set_geometry(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                   16'($urandom_range(1, 65535)));
      random_phase(300);
      free_run = 1'b1;
      random_phase(150);
      free_run = 1'b0;
      set_geometry(16'($urandom_range(1, 200)), 16'($urandom_range(1, 200)),
                   16'($urandom_range(1, 65535)));
      random_phase(400);
      set_geometry(16'hFFFF, 16'($urandom_range(1, 65535)), 16'hFFFF);
      random_phase(200);
      set_geometry(16'($urandom_range(1, 65535)), 16'd0, 16'($urandom_range(1, 65535)));
      random_phase(150);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0; kind = KIND_TICK; left_speed = '0; right_speed = '0;
    x_in = '0; y_in = '0; heading_in = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    radius_q = 64'(RADIUS_RST); spacing_q = 64'(SPACING_RST); tick_q = 64'(TICK_RST);
    pose_x = '0; pose_y = '0; pose_heading = '0;
    fail_count = 0; word_count = 0; tick_count = 0; place_count = 0; result_count = 0;
    free_run = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_extreme_geometry();
    test_random();
    drain();
    repeat (100) @(posedge clk);
    $display("words sent %0d (%0d ticks, %0d places), results checked %0d",
             word_count, tick_count, place_count, result_count);
    $display("geometry phases covered reset, extreme, zero-spacing and random settings");
    if (fail_count == 0 && pose_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
